/* sv/tws_pkg.sv */
// Shared types, constants and helpers of the three-wire serial register access block.
package tws_pkg;

   localparam int WAIT_WIDTH = 16;
   localparam int CFG_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int BIT_COUNT_WIDTH = 4;

   localparam logic [WAIT_WIDTH-1:0] WAIT_MAX = {WAIT_WIDTH{1'b1}};

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_SETUP_TICKS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRITE_GAP_TICKS = 2'd2;

   localparam logic [CFG_WIDTH-1:0] PHASE_TICKS_RESET = 16'd30;
   localparam logic [CFG_WIDTH-1:0] READ_SETUP_TICKS_RESET = 16'd300;
   localparam logic [CFG_WIDTH-1:0] WRITE_GAP_TICKS_RESET = 16'd1000;

   localparam logic [BIT_COUNT_WIDTH-1:0] BIT_LAST = 4'd15;
   localparam logic [BIT_COUNT_WIDTH-1:0] BIT_FIRST_READ = 4'd8;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] phase_ticks;
      logic [CFG_WIDTH-1:0] read_enable_setup_ticks;
      logic [CFG_WIDTH-1:0] write_bit_gap_ticks;
   } cfg_type;

   // Saturates a wait length to the counter width and treats zero as one.
   function automatic logic [WAIT_WIDTH-1:0] load_wait(input logic [CFG_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w > 32'(WAIT_MAX)) begin
         w = 32'(WAIT_MAX);
      end
      if (w == 32'd0) begin
         w = 32'd1;
      end
      return WAIT_WIDTH'(w);
   endfunction

endpackage

/* sv/tws_csr.sv */
// Configuration registers of the three-wire serial register access block.
module tws_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tws_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tws_pkg::CFG_WIDTH-1:0]         csr_data,
   output tws_pkg::cfg_type                      cfg
);

   tws_pkg::cfg_type cfg_ff;
   tws_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tws_pkg::CSR_PHASE_TICKS: cfg_in.phase_ticks = csr_data;
            tws_pkg::CSR_READ_SETUP_TICKS: cfg_in.read_enable_setup_ticks = csr_data;
            tws_pkg::CSR_WRITE_GAP_TICKS: cfg_in.write_bit_gap_ticks = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks <= tws_pkg::PHASE_TICKS_RESET;
         cfg_ff.read_enable_setup_ticks <= tws_pkg::READ_SETUP_TICKS_RESET;
         cfg_ff.write_bit_gap_ticks <= tws_pkg::WRITE_GAP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/three_wire_serial_register_access.sv */
// Top level of the three-wire serial register access master, one timing tick per word.
//
//   Channel  Direction  Handshake              Word
//   req_     in         req_valid/req_stall    start, opcode, address, data, line level
//   rsp_     out        rsp_valid/rsp_stall    pin levels, busy, done, read byte
//   csr_     in         csr_valid/csr_ready    register index and value
//
// Each request word is one tick; a word is taken every cycle unless the response side
// stalls, and its response appears in the next cycle from the response register.
// The sequencer state advances only when a request word is taken.
// A stalled response holds the response register and stalls the request side.
// Reset returns the sequencer to idle with all pins low and the timing registers
// to their default values.
module three_wire_serial_register_access (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_req,
   input  logic                                req_opcode,
   input  logic [7:0]                          req_reg_address,
   input  logic [7:0]                          req_write_data,
   input  logic                                req_line_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_serial_clock,
   output logic                                rsp_chip_enable,
   output logic                                rsp_line_out,
   output logic                                rsp_line_drive,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [7:0]                          rsp_read_byte,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tws_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tws_pkg::CFG_WIDTH-1:0]       csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PRE,
      S_SETUP,
      S_LOW,
      S_DATA,
      S_HIGH,
      S_GAP,
      S_TAIL
   } state_type;

   tws_pkg::cfg_type cfg;

   state_type                              state_ff, state_in;
   logic [tws_pkg::WAIT_WIDTH-1:0]         wait_ff, wait_in;
   logic [tws_pkg::BIT_COUNT_WIDTH-1:0]    bit_ff, bit_in;
   logic [15:0]                            out_shift_ff, out_shift_in;
   logic [7:0]                             in_shift_ff, in_shift_in;
   logic                                   read_mode_ff, read_mode_in;
   logic                                   clk_ff, clk_in;
   logic                                   ce_ff, ce_in;
   logic                                   out_ff, out_in;
   logic                                   drive_ff, drive_in;
   logic                                   done_in;
   logic [7:0]                             read_byte_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_clk_ff, rsp_ce_ff, rsp_out_ff, rsp_drive_ff;
   logic                                   rsp_busy_ff, rsp_done_ff;
   logic [7:0]                             rsp_read_byte_ff;

   logic                                   accept;
   logic                                   write_slot;

   tws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign write_slot = ~read_mode_ff | (bit_ff < tws_pkg::BIT_FIRST_READ);

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      bit_in = bit_ff;
      out_shift_in = out_shift_ff;
      in_shift_in = in_shift_ff;
      read_mode_in = read_mode_ff;
      clk_in = clk_ff;
      ce_in = ce_ff;
      out_in = out_ff;
      drive_in = drive_ff;
      done_in = 1'b0;
      read_byte_in = 8'd0;
      if (accept) begin
         if (state_ff == S_IDLE) begin
            if (req_start_req) begin
               read_mode_in = req_opcode;
               out_shift_in = {(req_opcode ? 8'd0 : req_write_data), req_reg_address};
               in_shift_in = 8'd0;
               bit_in = '0;
               clk_in = 1'b0;
               ce_in = 1'b0;
               state_in = S_PRE;
               wait_in = tws_pkg::load_wait(cfg.phase_ticks);
            end
         end else if (wait_ff > tws_pkg::WAIT_WIDTH'(1)) begin
            wait_in = wait_ff - tws_pkg::WAIT_WIDTH'(1);
         end else begin
            wait_in = '0;
            case (state_ff)
               S_PRE: begin
                  ce_in = 1'b1;
                  drive_in = 1'b1;
                  out_in = 1'b0;
                  if (read_mode_ff && cfg.read_enable_setup_ticks != '0) begin
                     state_in = S_SETUP;
                     wait_in = tws_pkg::load_wait(cfg.read_enable_setup_ticks);
                  end else begin
                     clk_in = 1'b0;
                     state_in = S_LOW;
                     wait_in = tws_pkg::load_wait(cfg.phase_ticks);
                  end
               end
               S_SETUP: begin
                  clk_in = 1'b0;
                  state_in = S_LOW;
                  wait_in = tws_pkg::load_wait(cfg.phase_ticks);
               end
               S_LOW: begin
                  if (write_slot) begin
                     out_in = out_shift_ff[bit_ff];
                     state_in = S_DATA;
                  end else begin
                     in_shift_in = {req_line_in, in_shift_ff[7:1]};
                     clk_in = 1'b1;
                     state_in = S_HIGH;
                  end
                  wait_in = tws_pkg::load_wait(cfg.phase_ticks);
               end
               S_DATA: begin
                  clk_in = 1'b1;
                  state_in = S_HIGH;
                  wait_in = tws_pkg::load_wait(cfg.phase_ticks);
               end
               S_HIGH, S_GAP: begin
                  if (state_ff == S_HIGH && write_slot && cfg.write_bit_gap_ticks != '0) begin
                     state_in = S_GAP;
                     wait_in = tws_pkg::load_wait(cfg.write_bit_gap_ticks);
                  end else if (bit_ff >= tws_pkg::BIT_LAST) begin
                     state_in = S_TAIL;
                     if (read_mode_ff) begin
                        bit_in = '0;
                     end else begin
                        bit_in = tws_pkg::BIT_COUNT_WIDTH'(1);
                        clk_in = 1'b0;
                     end
                     wait_in = tws_pkg::load_wait(cfg.phase_ticks);
                  end else begin
                     bit_in = bit_ff + tws_pkg::BIT_COUNT_WIDTH'(1);
                     if (read_mode_ff && bit_in == tws_pkg::BIT_FIRST_READ) begin
                        drive_in = 1'b0;
                        out_in = 1'b0;
                     end
                     clk_in = 1'b0;
                     state_in = S_LOW;
                     wait_in = tws_pkg::load_wait(cfg.phase_ticks);
                  end
               end
               S_TAIL: begin
                  if (bit_ff == '0) begin
                     bit_in = tws_pkg::BIT_COUNT_WIDTH'(1);
                     clk_in = 1'b0;
                     wait_in = tws_pkg::load_wait(cfg.phase_ticks);
                  end else begin
                     clk_in = 1'b0;
                     ce_in = 1'b0;
                     drive_in = 1'b0;
                     out_in = 1'b0;
                     done_in = 1'b1;
                     read_byte_in = read_mode_ff ? in_shift_ff : 8'd0;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff <= '0;
         bit_ff <= '0;
         out_shift_ff <= '0;
         in_shift_ff <= '0;
         read_mode_ff <= 1'b0;
         clk_ff <= 1'b0;
         ce_ff <= 1'b0;
         out_ff <= 1'b0;
         drive_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_clk_ff <= 1'b0;
         rsp_ce_ff <= 1'b0;
         rsp_out_ff <= 1'b0;
         rsp_drive_ff <= 1'b0;
         rsp_busy_ff <= 1'b0;
         rsp_done_ff <= 1'b0;
         rsp_read_byte_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         bit_ff <= bit_in;
         out_shift_ff <= out_shift_in;
         in_shift_ff <= in_shift_in;
         read_mode_ff <= read_mode_in;
         clk_ff <= clk_in;
         ce_ff <= ce_in;
         out_ff <= out_in;
         drive_ff <= drive_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            rsp_clk_ff <= clk_in;
            rsp_ce_ff <= ce_in;
            rsp_out_ff <= drive_in & out_in;
            rsp_drive_ff <= drive_in;
            rsp_busy_ff <= (state_in != S_IDLE);
            rsp_done_ff <= done_in;
            rsp_read_byte_ff <= read_byte_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_serial_clock = rsp_clk_ff;
   assign rsp_chip_enable = rsp_ce_ff;
   assign rsp_line_out = rsp_out_ff;
   assign rsp_line_drive = rsp_drive_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_read_byte = rsp_read_byte_ff;

`ifndef SYNTHESIS
   a_idle_pins_low: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ce_ff && !drive_ff && !clk_ff)
      else $error("sequencer idle with pins not low");

   a_done_ends_transaction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff && !rsp_ce_ff && !rsp_drive_ff)
      else $error("done word reports an open transaction");

   a_read_byte_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_done_ff |-> rsp_read_byte_ff == 8'd0)
      else $error("read byte set outside a done word");

   a_wait_nonzero_when_busy: assert property (@(posedge clock) disable iff (reset)
      accept && state_in != S_IDLE |=> wait_ff != '0)
      else $error("busy sequencer with empty wait counter");
`endif

endmodule
